### rtl/pqs_pkg.sv
// Shared types and constants for the ping-pong quintic sweep.
// Used by the channel interfaces, by pqs_poly and by the top module of the block.
package pqs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TIME_W        = 32;
    localparam int AMP_W         = 32;
    localparam int DUR_W         = 31;
    localparam int CFG_W         = 32;
    localparam int Q_W           = 32;

    typedef enum logic {
        CFG_AMPLITUDE = 1'b0,
        CFG_STROKE    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic first;
        logic odd;
    } t_stroke;

endpackage

### rtl/pqs_if.sv
// Channel interfaces of the ping-pong quintic sweep: time input, result output
// and configuration write. Depends on pqs_pkg.
interface pqs_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [pqs_pkg::TIME_W-1:0]  time_now;
    modport source (output valid, output time_now, input ready);
    modport sink   (input valid, input time_now, output ready);
endinterface

interface pqs_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [pqs_pkg::AMP_W-1:0]   position;
    logic signed [pqs_pkg::AMP_W-1:0]   velocity;
    logic                               velocity_saturated;
    modport source (output valid, output position, output velocity,
                    output velocity_saturated, input ready);
    modport sink   (input valid, input position, input velocity,
                    input velocity_saturated, output ready);
endinterface

interface pqs_cfg_if;
    logic                               valid;
    logic                               ready;
    pqs_pkg::t_cfg_idx                  index;
    logic [pqs_pkg::CFG_W-1:0]          data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/pqs_div_stage.sv
// One registered step of a restoring divider: produces one quotient bit.
// Carries a side payload along with the partial result. No package use.
module pqs_div_stage #(
    parameter int RW = 31,
    parameter int NW = 63,
    parameter int QW = 63,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [RW-1:0] i_divisor,
    input  logic          i_valid,
    input  logic [RW-1:0] i_rem,
    input  logic [NW-1:0] i_num,
    input  logic [QW-1:0] i_quo,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [RW-1:0] o_rem,
    output logic [NW-1:0] o_num,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic [RW:0]   trial;
    logic          ge;
    logic [RW-1:0] n_rem;
    logic          r_valid;
    logic [RW-1:0] r_rem;
    logic [NW-1:0] r_num;
    logic [QW-1:0] r_quo;
    logic [SW-1:0] r_side;

    assign trial = {i_rem, i_num[NW-1]};
    assign ge    = trial >= {1'b0, i_divisor};
    assign n_rem = ge ? RW'(trial - {1'b0, i_divisor}) : trial[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_num  <= {i_num[NW-2:0], 1'b0};
            r_quo  <= {i_quo[QW-2:0], ge};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

### rtl/pqs_poly.sv
// Quintic smoothstep and its derivative from the stroke fraction r (Q0.32).
// Five register stages: four products, then the weighted sums. Uses pqs_pkg.
module pqs_poly (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [pqs_pkg::Q_W-1:0] i_r,
    input  pqs_pkg::t_stroke       i_stroke,
    output logic                   o_valid,
    output logic [pqs_pkg::Q_W:0]  o_sq,
    output logic [pqs_pkg::Q_W+1:0] o_dq,
    output pqs_pkg::t_stroke       o_stroke
);

    localparam int W = pqs_pkg::Q_W;

    logic [4:0]             r_v;
    pqs_pkg::t_stroke       r_st [0:4];
    logic [W-1:0]           r_a1, r_a2;
    logic [W-1:0]           r_b1, r_b2, r_b3;
    logic [W-1:0]           r_c1, r_c2, r_c3, r_c4;
    logic                   r_d0;
    logic [W-1:0]           r_d2, r_d3, r_d4, r_d5;
    logic [W:0]             r_sq;
    logic [W+1:0]           r_dq;
    logic [2*W-1:0]         p1, p2, p3, p4;
    logic signed [W+5:0]    s_sum;
    logic signed [W+7:0]    ds_sum;
    logic [W:0]             n_sq;
    logic [W+1:0]           n_dq;

    assign p1 = (2*W)'(i_r) * (2*W)'(i_r);
    assign p2 = (2*W)'(r_a2) * (2*W)'(r_a1);
    assign p3 = (2*W)'(r_b3) * (2*W)'(r_b1);
    assign p4 = (2*W)'(r_c4) * (2*W)'(r_c1);

    assign s_sum = $signed((W+6)'(r_d3)) * 10 - $signed((W+6)'(r_d4)) * 15
                 + $signed((W+6)'(r_d5)) * 6;
    assign ds_sum = $signed((W+8)'(r_d2)) * 30 - $signed((W+8)'(r_d3)) * 60
                  + $signed((W+8)'(r_d4)) * 30;

    always_comb begin
        if (s_sum < 0) begin
            n_sq = '0;
        end else if (s_sum > $signed((W+6)'(1) <<< W)) begin
            n_sq = (W+1)'(1) << W;
        end else begin
            n_sq = s_sum[W:0];
        end
        if (ds_sum < 0 || !r_d0) begin
            n_dq = '0;
        end else begin
            n_dq = ds_sum[W+1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= i_stroke;
            r_st[1] <= r_st[0];
            r_st[2] <= r_st[1];
            r_st[3] <= r_st[2];
            r_st[4] <= r_st[3];
            r_a1 <= i_r;
            r_a2 <= p1[2*W-1:W];
            r_b1 <= r_a1;
            r_b2 <= r_a2;
            r_b3 <= p2[2*W-1:W];
            r_c1 <= r_b1;
            r_c2 <= r_b2;
            r_c3 <= r_b3;
            r_c4 <= p3[2*W-1:W];
            r_d0 <= r_c1 != '0;
            r_d2 <= r_c2;
            r_d3 <= r_c3;
            r_d4 <= r_c4;
            r_d5 <= p4[2*W-1:W];
            r_sq <= n_sq;
            r_dq <= n_dq;
        end
    end

    assign o_valid  = r_v[4];
    assign o_sq     = r_sq;
    assign o_dq     = r_dq;
    assign o_stroke = r_st[4];

endmodule

### rtl/ping_pong_quintic_sweep.sv
// Ping-pong quintic sweep: position and velocity of a back-and-forth stroke.
// The pipeline runs through the 63-step and 33-step pipelined dividers;
// throughput one sample per cycle while the output is not stalled. Reset clears amplitude, duration and all
// valid flags. Uses pqs_pkg, pqs_if, pqs_div_stage and pqs_poly.
module ping_pong_quintic_sweep #(
    parameter int FRAC_BITS = pqs_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pqs_in_if.sink          i_in,
    pqs_out_if.source       o_out,
    pqs_cfg_if.sink         i_cfg
);

    localparam int SH  = 32 - FRAC_BITS;
    localparam int RW  = pqs_pkg::DUR_W;
    localparam int QW  = pqs_pkg::Q_W;
    localparam int N1  = RW + QW;
    localparam int N2  = QW + 1;
    localparam int NXW = 2 * QW + 3;
    localparam int SW2 = QW + 2;

    logic signed [pqs_pkg::AMP_W-1:0] r_amp;
    logic [RW-1:0]                    r_dur;
    logic                             en;
    logic [RW-1:0]                    t_in;
    logic [QW-1:0]                    amag;
    logic                             a_neg;

    logic          d1_v    [0:N1];
    logic [RW-1:0] d1_rem  [0:N1];
    logic [N1-1:0] d1_num  [0:N1];
    logic [N1-1:0] d1_quo  [0:N1];
    logic          d1_side [0:N1];

    logic          d2_v    [0:N2];
    logic [RW-1:0] d2_rem  [0:N2];
    logic [N2-1:0] d2_num  [0:N2];
    logic [N2-1:0] d2_quo  [0:N2];
    logic [SW2-1:0] d2_side [0:N2];

    pqs_pkg::t_stroke       st_in, st_p;
    logic                   p_v;
    logic [QW:0]            p_sq;
    logic [QW+1:0]          p_dq;

    logic                   r_x_v;
    pqs_pkg::t_stroke       r_x_st;
    logic [2*QW:0]          r_x_pp;
    logic [2*QW+1:0]        r_x_pv;

    logic [2*QW+1:0]        pos_rnd;
    logic [QW-1:0]          term_mag;
    logic signed [QW+3:0]   term, pos_w;
    logic [QW-1:0]          n_pos;
    logic                   n_neg;
    logic [NXW-1:0]         nx, nxs, top;
    logic                   n_ovf;

    logic                   r_y_v;
    logic [QW-1:0]          r_y_pos;
    logic                   r_y_neg;
    logic                   r_y_ovf;
    logic [RW-1:0]          r_y_rem;
    logic [N2-1:0]          r_y_low;

    logic [N2-1:0]          lim;
    logic                   f_neg, f_ovf, f_sat;
    logic [N2-1:0]          f_mag;

    logic                   r_out_v;
    logic [QW-1:0]          r_out_pos, r_out_vel;
    logic                   r_out_sat;

    assign en          = !r_out_v || o_out.ready;
    assign i_in.ready  = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp <= '0;
            r_dur <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pqs_pkg::CFG_AMPLITUDE: r_amp <= $signed(i_cfg.data);
                pqs_pkg::CFG_STROKE:    r_dur <= i_cfg.data[RW-1:0];
            endcase
        end
    end

    assign a_neg = r_amp[pqs_pkg::AMP_W-1];
    assign amag  = a_neg ? QW'(-r_amp) : QW'(r_amp);
    assign t_in  = i_in.time_now[pqs_pkg::TIME_W-1] ? '0 : i_in.time_now[RW-1:0];

    assign d1_v[0]    = i_in.valid;
    assign d1_rem[0]  = '0;
    assign d1_num[0]  = {t_in, {QW{1'b0}}};
    assign d1_quo[0]  = '0;
    assign d1_side[0] = t_in < r_dur;

    for (genvar g = 0; g < N1; g++) begin : g_div1
        pqs_div_stage #(.RW(RW), .NW(N1), .QW(N1), .SW(1)) u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_divisor(r_dur),
            .i_valid(d1_v[g]), .i_rem(d1_rem[g]), .i_num(d1_num[g]),
            .i_quo(d1_quo[g]), .i_side(d1_side[g]),
            .o_valid(d1_v[g+1]), .o_rem(d1_rem[g+1]), .o_num(d1_num[g+1]),
            .o_quo(d1_quo[g+1]), .o_side(d1_side[g+1])
        );
    end

    assign st_in.first = d1_side[N1];
    assign st_in.odd   = d1_quo[N1][QW];

    pqs_poly u_poly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(d1_v[N1]), .i_r(d1_quo[N1][QW-1:0]), .i_stroke(st_in),
        .o_valid(p_v), .o_sq(p_sq), .o_dq(p_dq), .o_stroke(st_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v <= 1'b0;
        end else if (en) begin
            r_x_v <= p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x_st <= st_p;
            r_x_pp <= (2*QW+1)'(amag) * (2*QW+1)'(p_sq);
            r_x_pv <= (2*QW+2)'(amag) * (2*QW+2)'(p_dq);
        end
    end

    assign pos_rnd  = (2*QW+2)'(r_x_pp) + ((2*QW+2)'(1) << (QW-1));
    assign term_mag = pos_rnd[2*QW-1:QW];
    assign term     = a_neg ? -$signed((QW+4)'(term_mag)) : $signed((QW+4)'(term_mag));

    always_comb begin
        priority if (r_x_st.first) begin
            pos_w = term;
        end else if (r_x_st.odd) begin
            pos_w = (QW+4)'(r_amp) - (term <<< 1);
        end else begin
            pos_w = (term <<< 1) - (QW+4)'(r_amp);
        end
        if (pos_w > $signed((QW+4)'({1'b0, {(QW-1){1'b1}}}))) begin
            n_pos = {1'b0, {(QW-1){1'b1}}};
        end else if (pos_w < -$signed((QW+4)'({1'b1, {(QW-1){1'b0}}}))) begin
            n_pos = {1'b1, {(QW-1){1'b0}}};
        end else begin
            n_pos = pos_w[QW-1:0];
        end
    end

    assign n_neg = (a_neg != r_x_st.odd) && (r_amp != '0);
    assign nx    = (r_x_st.first ? NXW'(r_x_pv) : (NXW'(r_x_pv) << 1))
                 + (NXW'(r_dur) << (SH - 1));
    assign nxs   = nx >> SH;
    assign top   = nxs >> N2;
    assign n_ovf = top >= NXW'(r_dur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_v <= 1'b0;
        end else if (en) begin
            r_y_v <= r_x_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y_pos <= n_pos;
            r_y_neg <= n_neg;
            r_y_ovf <= n_ovf;
            r_y_rem <= top[RW-1:0];
            r_y_low <= nxs[N2-1:0];
        end
    end

    assign d2_v[0]    = r_y_v;
    assign d2_rem[0]  = r_y_rem;
    assign d2_num[0]  = r_y_low;
    assign d2_quo[0]  = '0;
    assign d2_side[0] = {r_y_pos, r_y_neg, r_y_ovf};

    for (genvar g = 0; g < N2; g++) begin : g_div2
        pqs_div_stage #(.RW(RW), .NW(N2), .QW(N2), .SW(SW2)) u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_divisor(r_dur),
            .i_valid(d2_v[g]), .i_rem(d2_rem[g]), .i_num(d2_num[g]),
            .i_quo(d2_quo[g]), .i_side(d2_side[g]),
            .o_valid(d2_v[g+1]), .o_rem(d2_rem[g+1]), .o_num(d2_num[g+1]),
            .o_quo(d2_quo[g+1]), .o_side(d2_side[g+1])
        );
    end

    assign f_neg = d2_side[N2][1];
    assign f_ovf = d2_side[N2][0];
    assign lim   = f_neg ? (N2'(1) << (QW-1)) : ((N2'(1) << (QW-1)) - N2'(1));
    assign f_sat = f_ovf || (d2_quo[N2] > lim);
    assign f_mag = f_sat ? lim : d2_quo[N2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= d2_v[N2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_dur == '0) begin
                r_out_pos <= '0;
                r_out_vel <= '0;
                r_out_sat <= 1'b0;
            end else begin
                r_out_pos <= d2_side[N2][SW2-1:2];
                r_out_vel <= f_neg ? QW'(-f_mag) : QW'(f_mag);
                r_out_sat <= f_sat;
            end
        end
    end

    assign o_out.valid              = r_out_v;
    assign o_out.position           = r_out_pos;
    assign o_out.velocity           = r_out_vel;
    assign o_out.velocity_saturated = r_out_sat;

endmodule

### dv/pqs_checker.sv
// Checker for the ping-pong quintic sweep: watches the configuration, input and
// result channels, predicts each result and compares it field by field.
// Depends on pqs_pkg and the channel interfaces in pqs_if.
module pqs_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pqs_in_if.sink    i_in,
    pqs_out_if.sink   i_out,
    pqs_cfg_if.sink   i_cfg,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = pqs_pkg::FRAC_BITS_DEF;

    typedef struct {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic               clipped;
    } t_sweep_point;

    logic signed [31:0] amplitude;
    logic [30:0]        duration;
    t_sweep_point       sweep_queue[$];

    function automatic t_sweep_point sweep_at(logic signed [31:0] t_in);
        t_sweep_point p;
        logic [63:0] t, k, rem, r, r2, r3, r4, r5, sq, dq, amag, tmag;
        logic [63:0] num, den, q, rm, dm, lim, mag;
        longint s, ds, a0, d, a, term, pos;
        logic neg;
        p.position = 0;
        p.velocity = 0;
        p.clipped  = 1'b0;
        if (duration == 0) return p;
        t    = t_in[31] ? 64'd0 : {32'd0, t_in};
        k    = t / duration;
        rem  = t % duration;
        r    = (rem << 32) / duration;
        r2   = (r * r) >> 32;
        r3   = (r2 * r) >> 32;
        r4   = (r3 * r) >> 32;
        r5   = (r4 * r) >> 32;
        s    = 10 * longint'(r3) - 15 * longint'(r4) + 6 * longint'(r5);
        if (s < 0) s = 0;
        if (s > 64'sh1_0000_0000) s = 64'sh1_0000_0000;
        sq   = s;
        ds   = 30 * longint'(r2) - 60 * longint'(r3) + 30 * longint'(r4);
        if (ds < 0 || r == 0) ds = 0;
        dq   = ds;
        if (k == 0) begin
            a0 = 0; d = 1;
        end else if (k[0]) begin
            a0 = 1; d = -2;
        end else begin
            a0 = -1; d = 2;
        end
        a    = amplitude;
        amag = (a < 0) ? -a : a;
        tmag = (amag * sq + 64'h8000_0000) >> 32;
        term = (a < 0) ? -longint'(tmag) : longint'(tmag);
        pos  = a * a0 + d * term;
        if (pos > 64'sh7FFF_FFFF) pos = 64'sh7FFF_FFFF;
        if (pos < -64'sh8000_0000) pos = -64'sh8000_0000;
        p.position = pos[31:0];
        num  = amag * dq;
        den  = {33'd0, duration} << (32 - FB);
        dm   = (d < 0) ? -d : d;
        q    = num / den;
        rm   = num % den;
        neg  = ((a < 0) != (d < 0)) && a != 0;
        lim  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (q >= 64'h2_0000_0000) begin
            mag = lim; p.clipped = 1'b1;
        end else begin
            mag = dm * q + (dm * rm + den / 2) / den;
            if (mag > lim) begin
                mag = lim; p.clipped = 1'b1;
            end
        end
        p.velocity = neg ? -mag[31:0] : mag[31:0];
        return p;
    endfunction

    assign o_pending = sweep_queue.size();

    always @(posedge i_clk) begin
        t_sweep_point want;
        if (!i_rst_n) begin
            amplitude <= 0;
            duration <= 0;
            o_fail_count <= 0;
            sweep_queue.delete();
        end else begin
            if (i_in.valid && i_in.ready) sweep_queue.push_back(sweep_at(i_in.time_now));
            if (i_out.valid && i_out.ready) begin
                if (sweep_queue.size() == 0) begin
                    $display("%0t: result with nothing expected: pos %h vel %h sat %b",
                             $time, i_out.position, i_out.velocity,
                             i_out.velocity_saturated);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = sweep_queue.pop_front();
                    if (want.position !== i_out.position
                            || want.velocity !== i_out.velocity
                            || want.clipped !== i_out.velocity_saturated) begin
                        $display("%0t: expected pos %h vel %h sat %b, got pos %h vel %h sat %b",
                                 $time, want.position, want.velocity, want.clipped,
                                 i_out.position, i_out.velocity, i_out.velocity_saturated);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    pqs_pkg::CFG_AMPLITUDE: amplitude <= i_cfg.data;
                    pqs_pkg::CFG_STROKE:    duration <= i_cfg.data[30:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

### dv/tb_top.sv
// Top of the ping-pong quintic sweep testbench: clock, reset, stimulus and verdict.
// Depends on pqs_pkg, pqs_if, the block and pqs_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 104;
    localparam int STALL_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    bit   sink_hold = 1'b0;

    pqs_in_if  in_ch();
    pqs_out_if out_ch();
    pqs_cfg_if cfg_ch();

    ping_pong_quintic_sweep DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    pqs_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch.sink),
        .i_out        (out_ch.sink),
        .i_cfg        (cfg_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.time_now = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = pqs_pkg::CFG_AMPLITUDE;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // The receiver alternates between free-running stretches and random stalls.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 99) < 3) sink_hold <= ~sink_hold;
        out_ch.ready <= sink_hold ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) != 0);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(pqs_pkg::t_cfg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic send_sample(logic [31:0] t);
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.time_now <= t;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic send_random(int count, logic [31:0] dur);
        int burst;
        logic [31:0] t;
        while (count > 0) begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst && count > 0; i++) begin
                case ($urandom_range(0, 9))
                    0: t = $urandom;
                    1: t = 32'h8000_0000 | $urandom;
                    2: t = dur * $urandom_range(0, 6);
                    3: t = dur * $urandom_range(0, 6) + $urandom_range(0, 3);
                    default: t = (dur != 0) ? $urandom % (dur * 6 + 1) : $urandom;
                endcase
                if (t[31] && $urandom_range(0, 3) != 0) t = $urandom_range(0, 1000);
                send_sample(t);
                count--;
            end
            if ($urandom_range(0, 2) != 0) begin
                end_burst();
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
        end_burst();
    endtask

    initial begin
        logic [31:0] amp_set[7];
        logic [31:0] dur_set[7];
        amp_set = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000,
                    32'h0000_0000, 32'h0050_0000, 32'hFFA3_1234};
        dur_set = '{32'h0000_0001, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_8000,
                    32'h0000_0000, 32'h0003_0000, 32'h0000_0010};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero duration before any write, then the directed corners.
        send_sample(32'h0001_0000);
        end_burst();
        drain_results();
        write_reg(pqs_pkg::CFG_AMPLITUDE, 32'h0002_0000);
        write_reg(pqs_pkg::CFG_STROKE, 32'h0001_0000);
        send_sample(32'h0000_0000);
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0000_8000);
        send_sample(32'h0001_0000);
        send_sample(32'h0001_8000);
        send_sample(32'h0002_0000);
        send_sample(32'h0002_8000);
        send_sample(32'h0003_0000);
        send_sample(32'h0000_0001);
        send_sample(32'h0001_FFFF);
        end_burst();
        drain_results();
        write_reg(pqs_pkg::CFG_AMPLITUDE, 32'h8000_0000);
        write_reg(pqs_pkg::CFG_STROKE, 32'h0000_0001);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_0001);
        send_sample(32'h0000_0002);
        send_sample(32'h5555_5555);
        end_burst();
        drain_results();
        write_reg(pqs_pkg::CFG_AMPLITUDE, 32'h7FFF_FFFF);
        write_reg(pqs_pkg::CFG_STROKE, 32'h7FFF_FFFF);
        send_sample(32'h4000_0000);
        send_sample(32'h7FFF_FFFE);
        send_sample(32'h0000_0007);
        end_burst();
        drain_results();

        for (int ph = 0; ph < 14; ph++) begin
            logic [31:0] dur;
            dur = ph < 7 ? dur_set[ph] : ($urandom_range(0, 1) ? $urandom_range(1, 32'h0004_0000)
                                                              : ($urandom & 32'h7FFF_FFFF));
            write_reg(pqs_pkg::CFG_AMPLITUDE, ph < 7 ? amp_set[ph] : $urandom);
            write_reg(pqs_pkg::CFG_STROKE, dur);
            send_random(102, dur);
            drain_results();
        end

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
